/* rtl/core/ctrl_pkg.sv */
// ----------------------------------------------------------------------------
// ctrl_pkg
// Shared widths, types and codes for the nearest-timestamp ring lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ctrl_pkg;

  // field widths
  localparam int TS_W    = 48;
  localparam int RATE_W  = 16;
  localparam int IDX_W   = 10;
  localparam int ENTRY_W = TS_W + 3 * RATE_W;

  // ring geometry and search bound
  localparam int RING_DEPTH_DEF    = 1024;
  localparam int SEARCH_STEP_LIMIT = 64;
  localparam int STEP_W            = $clog2(SEARCH_STEP_LIMIT + 1);

  // command codes
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // one ring entry as held in memory
  typedef struct packed {
    logic [TS_W-1:0]          ts;
    logic signed [RATE_W-1:0] rate_p;
    logic signed [RATE_W-1:0] rate_q;
    logic signed [RATE_W-1:0] rate_r;
  } ctrl_entry_t;

  // query sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_NEIGHBOR,
    ST_DONE
  } ctrl_state_t;

endpackage

`default_nettype wire

/* rtl/core/ctrl_if.sv */
// ----------------------------------------------------------------------------
// ctrl_if
// Valid/ready channels for sample words in and match words out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ctrl_in_if;
  import ctrl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [TS_W-1:0]          timestamp;
  logic signed [RATE_W-1:0] rate_p;
  logic signed [RATE_W-1:0] rate_q;
  logic signed [RATE_W-1:0] rate_r;

  modport source (
    output valid, command, timestamp, rate_p, rate_q, rate_r,
    input  ready
  );

  modport sink (
    input  valid, command, timestamp, rate_p, rate_q, rate_r,
    output ready
  );
endinterface

interface ctrl_out_if;
  import ctrl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         match_index;
  logic [TS_W-1:0]          match_time;
  logic signed [RATE_W-1:0] match_p;
  logic signed [RATE_W-1:0] match_q;
  logic signed [RATE_W-1:0] match_r;

  modport source (
    output valid, match_index, match_time, match_p, match_q, match_r,
    input  ready
  );

  modport sink (
    input  valid, match_index, match_time, match_p, match_q, match_r,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/ctrl_ram.sv */
// ----------------------------------------------------------------------------
// ctrl_ram
// Generic single-port synchronous RAM, one access a cycle, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctrl_ram #(
  parameter int WIDTH = ctrl_pkg::ENTRY_W,
  parameter int DEPTH = ctrl_pkg::RING_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/closest_timestamp_ring_lookup.sv */
// ----------------------------------------------------------------------------
// closest_timestamp_ring_lookup
// Ring of time-stamped gyro rate samples with nearest-timestamp query.
// ----------------------------------------------------------------------------
// A store word (command 0) writes timestamp and rates at the write pointer
// and gives no result; the next word may follow at once. A query word
// (command 1) binary-searches the ring by age (offset 0 is the newest
// sample), then, unless it hits a timestamp exactly, reads one neighbour of
// the entry found and returns whichever is nearer in time, keeping the found
// entry on a tie. The ring sits in one single-port RAM with a registered
// read, so each probe waits for its read: a query passes through the
// accept, the search probes (at most SEARCH_STEP_LIMIT + 1 reads), the
// neighbour read and the hand-off, which waits while the previous match
// word is not yet taken. Inputs are held off while a query is in progress.
// No clearing pass runs after reset: slots not yet written since reset read
// as zero, tracked by the write pointer and a wrap flag. The result sits in
// an output register, so stores keep flowing while a match word waits to be
// taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module closest_timestamp_ring_lookup #(
  parameter int RING_DEPTH = ctrl_pkg::RING_DEPTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  ctrl_in_if.sink    in_ch,
  ctrl_out_if.source out_ch
);
  import ctrl_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int SW = AW + 1;
  localparam logic [AW-1:0] LAST   = AW'(RING_DEPTH - 1);
  localparam logic [AW-1:0] PROBE0 = AW'((RING_DEPTH - 1) / 2);

  // slot of an age offset: (wp - 1 - off) mod depth
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] wp,
                                             input logic [AW-1:0] off);
    logic [SW-1:0] s;
    s = {1'b0, wp} + SW'(RING_DEPTH - 1) - {1'b0, off};
    if (s >= SW'(RING_DEPTH)) begin
      s = s - SW'(RING_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // state
  ctrl_state_t      state_r, state_nxt;
  logic [AW-1:0]    wp_r, wp_nxt;
  logic             wrapped_r, wrapped_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [AW-1:0]    lower_r, lower_nxt;
  logic [AW-1:0]    upper_r, upper_nxt;
  logic [AW-1:0]    probe_r, probe_nxt;
  logic [AW-1:0]    slot_r, slot_nxt;
  logic [AW-1:0]    nb_slot_r, nb_slot_nxt;
  logic             rd_ok_r, rd_ok_nxt;
  logic [TS_W-1:0]  q_r, q_nxt;
  logic [AW-1:0]    found_slot_r, found_slot_nxt;
  ctrl_entry_t      found_ent_r, found_ent_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [AW-1:0]    out_slot_r;
  ctrl_entry_t      out_ent_r;

  // memory port
  logic             ram_en;
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  ctrl_entry_t      ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  ctrl_entry_t      ent_rd;

  logic             in_fire;
  logic             out_free;
  logic             out_load;

  ctrl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // a slot never written since reset reads as zero
  assign ent_rd = rd_ok_r ? ctrl_entry_t'(ram_rdata) : '0;

  function automatic logic slot_ok(input logic [AW-1:0] slot,
                                   input logic [AW-1:0] wp,
                                   input logic wrapped);
    return wrapped || (slot < wp);
  endfunction

  // probe candidates toward older and toward newer, chosen by the compare
  logic [AW-1:0] probe_up, probe_dn, slot_up, slot_dn;
  logic [AW-1:0] nb_minus, nb_plus;
  assign probe_up = probe_r + ((upper_r - probe_r) >> 1);
  assign probe_dn = probe_r - ((probe_r - lower_r) >> 1);
  assign slot_up  = slot_of(wp_r, probe_up);
  assign slot_dn  = slot_of(wp_r, probe_dn);
  assign nb_minus = (slot_r == '0) ? LAST : slot_r - AW'(1);
  assign nb_plus  = (slot_r == LAST) ? '0 : slot_r + AW'(1);

  // search step tests
  logic q_lt_t, q_eq_t, stop;
  assign q_lt_t = q_r < ent_rd.ts;
  assign q_eq_t = q_r == ent_rd.ts;
  assign stop   = q_eq_t || ((upper_r - lower_r) <= AW'(1))
                  || (steps_r == STEP_W'(SEARCH_STEP_LIMIT));

  // neighbour distances
  logic [TS_W-1:0] dist_found, dist_nb;
  assign dist_found = (q_r >= found_ent_r.ts) ? q_r - found_ent_r.ts
                                              : found_ent_r.ts - q_r;
  assign dist_nb    = (q_r >= ent_rd.ts) ? q_r - ent_rd.ts : ent_rd.ts - q_r;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign ram_wdata.ts     = in_ch.timestamp;
  assign ram_wdata.rate_p = in_ch.rate_p;
  assign ram_wdata.rate_q = in_ch.rate_q;
  assign ram_wdata.rate_r = in_ch.rate_r;

  // sequencer: next state, memory access, search registers
  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    wrapped_nxt    = wrapped_r;
    steps_nxt      = steps_r;
    lower_nxt      = lower_r;
    upper_nxt      = upper_r;
    probe_nxt      = probe_r;
    slot_nxt       = slot_r;
    nb_slot_nxt    = nb_slot_r;
    rd_ok_nxt      = rd_ok_r;
    q_nxt          = q_r;
    found_slot_nxt = found_slot_r;
    found_ent_nxt  = found_ent_r;
    ram_en         = 1'b0;
    ram_we         = 1'b0;
    ram_addr       = wp_r;
    out_load       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.command == CMD_STORE) begin
            ram_en      = 1'b1;
            ram_we      = 1'b1;
            ram_addr    = wp_r;
            wp_nxt      = (wp_r == LAST) ? '0 : wp_r + AW'(1);
            wrapped_nxt = wrapped_r || (wp_r == LAST);
          end else begin
            q_nxt     = in_ch.timestamp;
            lower_nxt = '0;
            upper_nxt = LAST;
            probe_nxt = PROBE0;
            steps_nxt = '0;
            slot_nxt  = slot_of(wp_r, PROBE0);
            ram_en    = 1'b1;
            ram_addr  = slot_nxt;
            rd_ok_nxt = slot_ok(slot_nxt, wp_r, wrapped_r);
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (stop) begin
          found_slot_nxt = slot_r;
          found_ent_nxt  = ent_rd;
          if (q_eq_t) begin
            state_nxt = ST_DONE;
          end else begin
            nb_slot_nxt = q_lt_t ? nb_minus : nb_plus;
            ram_en      = 1'b1;
            ram_addr    = nb_slot_nxt;
            rd_ok_nxt   = slot_ok(nb_slot_nxt, wp_r, wrapped_r);
            state_nxt   = ST_NEIGHBOR;
          end
        end else begin
          if (q_lt_t) begin
            lower_nxt = probe_r;
            probe_nxt = probe_up;
            slot_nxt  = slot_up;
          end else begin
            upper_nxt = probe_r;
            probe_nxt = probe_dn;
            slot_nxt  = slot_dn;
          end
          steps_nxt = steps_r + STEP_W'(1);
          ram_en    = 1'b1;
          ram_addr  = slot_nxt;
          rd_ok_nxt = slot_ok(slot_nxt, wp_r, wrapped_r);
        end
      end
      ST_NEIGHBOR: begin
        if (dist_nb < dist_found) begin
          found_slot_nxt = nb_slot_r;
          found_ent_nxt  = ent_rd;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      wrapped_r   <= wrapped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // search and payload registers
  always_ff @(posedge clk) begin
    steps_r      <= steps_nxt;
    lower_r      <= lower_nxt;
    upper_r      <= upper_nxt;
    probe_r      <= probe_nxt;
    slot_r       <= slot_nxt;
    nb_slot_r    <= nb_slot_nxt;
    rd_ok_r      <= rd_ok_nxt;
    q_r          <= q_nxt;
    found_slot_r <= found_slot_nxt;
    found_ent_r  <= found_ent_nxt;
    if (out_load) begin
      out_slot_r <= found_slot_r;
      out_ent_r  <= found_ent_r;
    end
  end

  // ports
  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.match_index = IDX_W'(out_slot_r);
  assign out_ch.match_time  = out_ent_r.ts;
  assign out_ch.match_p     = out_ent_r.rate_p;
  assign out_ch.match_q     = out_ent_r.rate_q;
  assign out_ch.match_r     = out_ent_r.rate_r;

`ifndef ASSERT_OFF
  // no ring write while a query owns the memory
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !ram_we)
    else $error("ring written during a query");

  // an accepted query starts the search next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.command == CMD_QUERY) |=> (state_r == ST_SEARCH))
    else $error("query did not start search");

  // probe stays within the search window
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (lower_r <= probe_r && probe_r <= upper_r))
    else $error("probe outside search window");

  // search step count never passes its bound
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (steps_r <= STEP_W'(SEARCH_STEP_LIMIT)))
    else $error("search step bound exceeded");

  // a new match word only comes from the hand-off state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("match word raised outside hand-off");
`endif

endmodule

`default_nettype wire
